[rtl/ilt_pkg.sv]
// idempotency ledger table: shared types, operation and outcome codes
// no dependencies; used by ilt_cell and idempotency_ledger_table
`default_nettype none
package ilt_pkg;

    localparam logic [1:0] OP_BEGIN    = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_ABANDON  = 2'd2;
    localparam logic [1:0] OP_CLEAR    = 2'd3;

    localparam logic [2:0] OUT_DISABLED   = 3'd0;
    localparam logic [2:0] OUT_FIRST      = 3'd1;
    localparam logic [2:0] OUT_CONFLICT   = 3'd2;
    localparam logic [2:0] OUT_IN_FLIGHT  = 3'd3;
    localparam logic [2:0] OUT_REPLAY     = 3'd4;
    localparam logic [2:0] OUT_DONE       = 3'd5;
    localparam logic [2:0] OUT_TABLE_FULL = 3'd6;

    localparam logic CFG_TTL_TICKS     = 1'b0;
    localparam logic CFG_MAX_COMPLETED = 1'b1;

    localparam logic [31:0] TTL_RESET       = 32'd1000000;
    localparam logic [5:0]  MAX_DONE_RESET  = 6'd32;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] slot_key;
        logic        key_present;
        logic [31:0] fingerprint;
        logic [31:0] receipt_handle;
        logic [31:0] now_time;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [31:0] replay_receipt;
        logic        receipt_valid;
    } out_beat_t;

    // partial scan result handed from cell to cell
    typedef struct packed {
        logic        active;
        logic        found;
        logic        f_done;
        logic        f_fpeq;
        logic        f_expired;
        logic [31:0] f_receipt;
        logic        free_found;
        logic        old_found;
        logic [31:0] old_order;
    } carry_t;

    // broadcast write command to the cells
    typedef struct packed {
        logic        ins;
        logic        inval;
        logic        set_done;
        logic        clr;
        logic [63:0] key;
        logic [31:0] fp;
        logic [31:0] order;
        logic [31:0] receipt;
        logic [31:0] done_time;
    } cmd_t;

endpackage
`default_nettype wire

[rtl/idempotency_ledger_table.sv]
// idempotency ledger table top level: sequencer, config registers and cell chain
// depends on ilt_pkg and ilt_cell
//
//  channel  | ports                   | direction | content
//  ---------+-------------------------+-----------+-----------------------------
//  request  | s_valid s_ready s_payload | in      | op, key, fingerprint, time
//  result   | m_valid m_ready m_payload | out     | outcome and replay receipt
//  config   | cfg_we cfg_idx cfg_wdata  | in      | ttl_ticks, max_completed
//
// one request beat at a time; a scan runs down the chain one cell per cycle;
// clear and requests without a key skip the scan and go straight to the response
// a complete that marks an entry adds a cap check, then one eviction scan
// for each entry evicted over the cap
// synchronous active-low reset empties the table; sequence restarts at 1
// a new request is taken while the previous result waits on m_ready
`default_nettype none
module idempotency_ledger_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ilt_pkg::in_beat_t    s_payload,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ilt_pkg::out_beat_t        m_payload,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_idx,
    input  wire logic [31:0]          cfg_wdata
);
    localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int CMW = (CW > 6) ? CW : 6;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_EVCHK  = 6'b001000,
        ST_EVSCAN = 6'b010000,
        ST_RESP   = 6'b100000
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [31:0] ttl_reg;
    logic [5:0]  cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg <= ilt_pkg::TTL_RESET;
            cap_reg <= ilt_pkg::MAX_DONE_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                ilt_pkg::CFG_TTL_TICKS:     ttl_reg <= cfg_wdata;
                ilt_pkg::CFG_MAX_COMPLETED: cap_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // held request beat, broadcast to every cell during a scan
    ilt_pkg::in_beat_t q_reg;

    // scan chain wiring
    ilt_pkg::carry_t c_chain [0:TABLE_DEPTH];
    logic [IW-1:0] found_chain [0:TABLE_DEPTH];
    logic [IW-1:0] free_chain  [0:TABLE_DEPTH];
    logic [IW-1:0] old_chain   [0:TABLE_DEPTH];

    logic            seed_reg;
    ilt_pkg::cmd_t   cmd_reg;
    logic [IW-1:0]   ins_idx_reg;
    logic [IW-1:0]   tgt_idx_reg;

    always_comb begin
        c_chain[0]        = '0;
        c_chain[0].active = seed_reg;
    end
    assign found_chain[0] = '0;
    assign free_chain[0]  = '0;
    assign old_chain[0]   = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        ilt_cell #(
            .IW  (IW),
            .IDX (g)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .q_key         (q_reg.slot_key),
            .q_fp          (q_reg.fingerprint),
            .q_now         (q_reg.now_time),
            .ttl           (ttl_reg),
            .c_in          (c_chain[g]),
            .found_idx_in  (found_chain[g]),
            .free_idx_in   (free_chain[g]),
            .old_idx_in    (old_chain[g]),
            .c_out         (c_chain[g+1]),
            .found_idx_out (found_chain[g+1]),
            .free_idx_out  (free_chain[g+1]),
            .old_idx_out   (old_chain[g+1]),
            .cmd           (cmd_reg),
            .ins_idx       (ins_idx_reg),
            .tgt_idx       (tgt_idx_reg)
        );
    end

    // result of the last lookup scan
    ilt_pkg::carry_t sc_reg;
    logic [IW-1:0]   sc_found_idx_reg;
    logic [IW-1:0]   sc_free_idx_reg;

    logic [31:0]        next_order_reg;
    logic [CW-1:0]      done_cnt_reg;
    ilt_pkg::out_beat_t res_reg;
    logic               m_valid_reg;
    ilt_pkg::out_beat_t m_payload_reg;

    ilt_pkg::carry_t last_c;
    logic            exp_drop;
    logic            take_found;
    logic            over_cap;

    assign last_c     = c_chain[TABLE_DEPTH];
    assign exp_drop   = sc_reg.found && sc_reg.f_done && sc_reg.f_expired;
    assign take_found = exp_drop &&
                        (!sc_reg.free_found || sc_found_idx_reg < sc_free_idx_reg);
    assign over_cap   = CMW'(done_cnt_reg) > CMW'(cap_reg);

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            seed_reg       <= 1'b0;
            cmd_reg        <= '0;
            next_order_reg <= 32'd1;
            done_cnt_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            seed_reg          <= 1'b0;
            cmd_reg.ins       <= 1'b0;
            cmd_reg.inval     <= 1'b0;
            cmd_reg.set_done  <= 1'b0;
            cmd_reg.clr       <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        q_reg   <= s_payload;
                        res_reg <= '{outcome: ilt_pkg::OUT_DONE,
                                     replay_receipt: 32'd0, receipt_valid: 1'b0};
                        if (s_payload.op == ilt_pkg::OP_CLEAR) begin
                            cmd_reg.clr    <= 1'b1;
                            next_order_reg <= 32'd1;
                            done_cnt_reg   <= '0;
                            state_reg      <= ST_RESP;
                        end else if (!s_payload.key_present) begin
                            if (s_payload.op == ilt_pkg::OP_BEGIN) begin
                                res_reg.outcome <= ilt_pkg::OUT_DISABLED;
                            end
                            state_reg <= ST_RESP;
                        end else begin
                            seed_reg  <= 1'b1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (last_c.active) begin
                        sc_reg           <= last_c;
                        sc_found_idx_reg <= found_chain[TABLE_DEPTH];
                        sc_free_idx_reg  <= free_chain[TABLE_DEPTH];
                        state_reg        <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    state_reg <= ST_RESP;
                    case (q_reg.op)
                        ilt_pkg::OP_BEGIN: begin
                            if (sc_reg.found && !exp_drop) begin
                                if (!sc_reg.f_fpeq) begin
                                    res_reg.outcome <= ilt_pkg::OUT_CONFLICT;
                                end else if (!sc_reg.f_done) begin
                                    res_reg.outcome <= ilt_pkg::OUT_IN_FLIGHT;
                                end else begin
                                    res_reg.outcome        <= ilt_pkg::OUT_REPLAY;
                                    res_reg.replay_receipt <= sc_reg.f_receipt;
                                    res_reg.receipt_valid  <= 1'b1;
                                end
                            end else begin
                                // expired entry is dropped in the same cycle as the insert
                                if (exp_drop) begin
                                    cmd_reg.inval <= 1'b1;
                                    tgt_idx_reg   <= sc_found_idx_reg;
                                    done_cnt_reg  <= done_cnt_reg - CW'(1);
                                end
                                if (exp_drop || sc_reg.free_found) begin
                                    cmd_reg.ins    <= 1'b1;
                                    ins_idx_reg    <= take_found ? sc_found_idx_reg
                                                                 : sc_free_idx_reg;
                                    cmd_reg.key    <= q_reg.slot_key;
                                    cmd_reg.fp     <= q_reg.fingerprint;
                                    cmd_reg.order  <= next_order_reg;
                                    next_order_reg <= next_order_reg + 32'd1;
                                    res_reg.outcome <= ilt_pkg::OUT_FIRST;
                                end else begin
                                    res_reg.outcome <= ilt_pkg::OUT_TABLE_FULL;
                                end
                            end
                        end
                        ilt_pkg::OP_COMPLETE: begin
                            if (sc_reg.found && !sc_reg.f_done) begin
                                cmd_reg.set_done  <= 1'b1;
                                tgt_idx_reg       <= sc_found_idx_reg;
                                cmd_reg.receipt   <= q_reg.receipt_handle;
                                cmd_reg.done_time <= q_reg.now_time;
                                done_cnt_reg      <= done_cnt_reg + CW'(1);
                                state_reg         <= ST_EVCHK;
                            end
                        end
                        ilt_pkg::OP_ABANDON: begin
                            if (sc_reg.found) begin
                                cmd_reg.inval <= 1'b1;
                                tgt_idx_reg   <= sc_found_idx_reg;
                                if (sc_reg.f_done) begin
                                    done_cnt_reg <= done_cnt_reg - CW'(1);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                ST_EVCHK: begin
                    // pending write lands this cycle, before the seed reaches cell 0
                    if (over_cap) begin
                        seed_reg  <= 1'b1;
                        state_reg <= ST_EVSCAN;
                    end else begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_EVSCAN: begin
                    if (last_c.active) begin
                        cmd_reg.inval <= 1'b1;
                        tgt_idx_reg   <= old_chain[TABLE_DEPTH];
                        done_cnt_reg  <= done_cnt_reg - CW'(1);
                        state_reg     <= ST_EVCHK;
                    end
                end
                ST_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_payload_reg <= res_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
`default_nettype wire

[rtl/ilt_cell.sv]
// one table entry plus its stage of the scan chain
// depends on ilt_pkg
`default_nettype none
module ilt_cell #(
    parameter int IW  = 5,
    parameter int IDX = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [63:0]       q_key,
    input  wire logic [31:0]       q_fp,
    input  wire logic [31:0]       q_now,
    input  wire logic [31:0]       ttl,
    input  wire ilt_pkg::carry_t   c_in,
    input  wire logic [IW-1:0]     found_idx_in,
    input  wire logic [IW-1:0]     free_idx_in,
    input  wire logic [IW-1:0]     old_idx_in,
    output ilt_pkg::carry_t        c_out,
    output logic [IW-1:0]          found_idx_out,
    output logic [IW-1:0]          free_idx_out,
    output logic [IW-1:0]          old_idx_out,
    input  wire ilt_pkg::cmd_t     cmd,
    input  wire logic [IW-1:0]     ins_idx,
    input  wire logic [IW-1:0]     tgt_idx
);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic        valid_reg;
    logic [63:0] key_reg;
    logic [31:0] fp_reg;
    logic        done_reg;
    logic [31:0] order_reg;
    logic [31:0] time_reg;
    logic [31:0] receipt_reg;

    ilt_pkg::carry_t c_reg, c_next;
    logic [IW-1:0] found_idx_reg, found_idx_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] old_idx_reg, old_idx_next;
    logic          hit;

    assign hit = valid_reg && (key_reg == q_key);

    always_comb begin
        c_next         = c_in;
        found_idx_next = found_idx_in;
        free_idx_next  = free_idx_in;
        old_idx_next   = old_idx_in;
        if (c_in.active) begin
            if (hit && !c_in.found) begin
                c_next.found     = 1'b1;
                c_next.f_done    = done_reg;
                c_next.f_fpeq    = (fp_reg == q_fp);
                c_next.f_expired = ((q_now - time_reg) > ttl);
                c_next.f_receipt = receipt_reg;
                found_idx_next   = MY_IDX;
            end
            if (!valid_reg && !c_in.free_found) begin
                c_next.free_found = 1'b1;
                free_idx_next     = MY_IDX;
            end
            if (valid_reg && done_reg &&
                (!c_in.old_found || order_reg < c_in.old_order)) begin
                c_next.old_found = 1'b1;
                c_next.old_order = order_reg;
                old_idx_next     = MY_IDX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg <= '0;
        end else begin
            c_reg <= c_next;
        end
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        old_idx_reg   <= old_idx_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.clr) begin
            valid_reg <= 1'b0;
        end else if (cmd.ins && ins_idx == MY_IDX) begin
            valid_reg <= 1'b1;
        end else if (cmd.inval && tgt_idx == MY_IDX) begin
            valid_reg <= 1'b0;
        end
        if (cmd.ins && ins_idx == MY_IDX) begin
            key_reg   <= cmd.key;
            fp_reg    <= cmd.fp;
            done_reg  <= 1'b0;
            order_reg <= cmd.order;
        end else if (cmd.set_done && tgt_idx == MY_IDX) begin
            done_reg    <= 1'b1;
            receipt_reg <= cmd.receipt;
            time_reg    <= cmd.done_time;
        end
    end

    assign c_out         = c_reg;
    assign found_idx_out = found_idx_reg;
    assign free_idx_out  = free_idx_reg;
    assign old_idx_out   = old_idx_reg;

endmodule
`default_nettype wire
